// ===== rtl/hvr_pkg.sv =====
`timescale 1ns / 1ps

package hvr_pkg;

    localparam int NUMBER_WIDTH = 16;
    localparam int OUT_WIDTH    = 16;
    localparam int ACC_WIDTH    = NUMBER_WIDTH + 4;
    localparam int WIDE_WIDTH   = 33;

    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = {NUMBER_WIDTH{1'b1}};
    localparam logic [OUT_WIDTH-1:0]    OUT_MAX = {OUT_WIDTH{1'b1}};

    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef logic [NUMBER_WIDTH-1:0] number_t;
    typedef logic [ACC_WIDTH-1:0]    acc_t;
    typedef logic [WIDE_WIDTH-1:0]   wide_t;
    typedef logic [OUT_WIDTH-1:0]    out_number_t;

    typedef enum logic [3:0] {
        PH_H1    = 4'd0,
        PH_T1    = 4'd1,
        PH_T2    = 4'd2,
        PH_P     = 4'd3,
        PH_SLASH = 4'd4,
        PH_MAJ0  = 4'd5,
        PH_MAJ   = 4'd6,
        PH_MIN0  = 4'd7,
        PH_MIN   = 4'd8,
        PH_CR    = 4'd9,
        PH_DONE  = 4'd10,
        PH_ERR   = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    typedef struct packed {
        phase_t  phase;
        number_t major_value;
        number_t minor_value;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_H1,
        major_value: '0,
        minor_value: '0
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic number_t accumulate(input number_t v, input logic [3:0] d);
        acc_t wv;
        acc_t n;
        wv = acc_t'(v);
        n  = (wv << 3) + (wv << 1) + acc_t'(d);
        return (n > acc_t'(NUM_MAX)) ? NUM_MAX : n[NUMBER_WIDTH-1:0];
    endfunction

    function automatic out_number_t clip_out(input number_t v);
        wide_t w;
        w = wide_t'(v);
        return (w > wide_t'(OUT_MAX)) ? OUT_MAX : w[OUT_WIDTH-1:0];
    endfunction

    function automatic status_t phase_status(input phase_t ph);
        if (ph == PH_DONE) begin
            return ST_COMPLETE;
        end else if (ph == PH_ERR) begin
            return ST_ERROR;
        end
        return ST_PARSING;
    endfunction

endpackage

// ===== rtl/hvr_step.sv =====
`timescale 1ns / 1ps

module hvr_step (
    input  hvr_pkg::parse_state_t state_in,
    input  logic [7:0]            byte_in,
    input  logic                  restart,
    output hvr_pkg::parse_state_t state_out
);

    hvr_pkg::parse_state_t cur;
    logic                  dig;
    logic [3:0]            dval;

    assign cur  = restart ? hvr_pkg::STATE_RESET : state_in;
    assign dig  = hvr_pkg::is_digit(byte_in);
    assign dval = byte_in[3:0];

    always_comb begin
        state_out = cur;
        unique case (cur.phase)
            hvr_pkg::PH_H1: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_H) ? hvr_pkg::PH_T1 : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_T1: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_T) ? hvr_pkg::PH_T2 : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_T2: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_T) ? hvr_pkg::PH_P : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_P: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_P) ? hvr_pkg::PH_SLASH
                                                               : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_SLASH: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_SLASH) ? hvr_pkg::PH_MAJ0
                                                                   : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_MAJ0: begin
                if (dig) begin
                    state_out.major_value = hvr_pkg::number_t'(dval);
                    state_out.phase       = hvr_pkg::PH_MAJ;
                end else begin
                    state_out.phase = hvr_pkg::PH_ERR;
                end
            end
            hvr_pkg::PH_MAJ: begin
                if (dig) begin
                    state_out.major_value = hvr_pkg::accumulate(cur.major_value, dval);
                end else if (byte_in == hvr_pkg::CHAR_DOT) begin
                    state_out.phase = hvr_pkg::PH_MIN0;
                end else begin
                    state_out.phase = hvr_pkg::PH_ERR;
                end
            end
            hvr_pkg::PH_MIN0: begin
                if (dig) begin
                    state_out.minor_value = hvr_pkg::number_t'(dval);
                    state_out.phase       = hvr_pkg::PH_MIN;
                end else begin
                    state_out.phase = hvr_pkg::PH_ERR;
                end
            end
            hvr_pkg::PH_MIN: begin
                if (dig) begin
                    state_out.minor_value = hvr_pkg::accumulate(cur.minor_value, dval);
                end else if (byte_in == hvr_pkg::CHAR_CR) begin
                    state_out.phase = hvr_pkg::PH_CR;
                end else if (byte_in == hvr_pkg::CHAR_LF) begin
                    state_out.phase = hvr_pkg::PH_DONE;
                end else begin
                    state_out.phase = hvr_pkg::PH_ERR;
                end
            end
            hvr_pkg::PH_CR: begin
                state_out.phase = (byte_in == hvr_pkg::CHAR_LF) ? hvr_pkg::PH_DONE
                                                                : hvr_pkg::PH_ERR;
            end
            hvr_pkg::PH_DONE: begin
                state_out.phase = hvr_pkg::PH_DONE;
            end
            default: begin
                state_out.phase = hvr_pkg::PH_ERR;
            end
        endcase
    end

endmodule

// ===== rtl/http_version_recognizer_top.sv =====
`timescale 1ns / 1ps

// channel   ports                                       role
// s_        s_valid s_ready s_byte_in s_restart         one byte of the version token
// m_        m_valid m_ready m_status m_major_number     one result per byte
//           m_minor_number
//
// one byte per cycle while s_ready is high; each result is registered at acceptance
// the parse state and the result register update together at the input beat
// aresetn (synchronous) returns the parser to expecting H with both numbers zero
// s_ready stays high while the result register is empty or being drained,
// so a stall on m_ only holds s_ for as long as m_ready is low

module http_version_recognizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_major_number,
    output logic [15:0] m_minor_number
);

    hvr_pkg::parse_state_t state_reg;
    hvr_pkg::parse_state_t state_next;
    logic                  m_valid_reg;
    hvr_pkg::status_t      status_reg;
    hvr_pkg::out_number_t  major_reg;
    hvr_pkg::out_number_t  minor_reg;
    logic                  s_beat;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    hvr_step u_step (
        .state_in  (state_reg),
        .byte_in   (s_byte_in),
        .restart   (s_restart),
        .state_out (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hvr_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            status_reg <= hvr_pkg::phase_status(state_next.phase);
            major_reg  <= hvr_pkg::clip_out(state_next.major_value);
            minor_reg  <= hvr_pkg::clip_out(state_next.minor_value);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_major_number = major_reg;
    assign m_minor_number = minor_reg;

endmodule
